### src/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

  localparam int MAX_LEAD_ZEROS = 16;
  localparam int MB_SHIFT       = 4;
  localparam int GW             = MAX_LEAD_ZEROS + 1;
  localparam int ZW             = $clog2(MAX_LEAD_ZEROS + 1);
  localparam int SZ_W           = GW + MB_SHIFT + 2;
  localparam int Q_DEPTH        = 2;
  localparam int QP_W           = $clog2(Q_DEPTH);

  localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [7:0] PROFILE_HIGH = 8'd100;
  localparam logic [7:0] EMU_BYTE     = 8'h03;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_SPS   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_SCALING   = 3'd3;
  localparam logic [2:0] ST_CODE_LONG = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  localparam logic [5:0] PH_HEADER  = 6'd0;
  localparam logic [5:0] PH_PROFILE = 6'd1;
  localparam logic [5:0] PH_CONSTR  = 6'd2;
  localparam logic [5:0] PH_LEVEL   = 6'd3;
  localparam logic [5:0] PH_ID      = 6'd4;
  localparam logic [5:0] PH_CHROMA  = 6'd5;
  localparam logic [5:0] PH_SEPCOL  = 6'd6;
  localparam logic [5:0] PH_DEPTHL  = 6'd7;
  localparam logic [5:0] PH_DEPTHC  = 6'd8;
  localparam logic [5:0] PH_QPBYP   = 6'd9;
  localparam logic [5:0] PH_SCALING = 6'd10;
  localparam logic [5:0] PH_LOG2FN  = 6'd11;
  localparam logic [5:0] PH_POCTYPE = 6'd12;
  localparam logic [5:0] PH_POCLSB  = 6'd13;
  localparam logic [5:0] PH_DZERO   = 6'd14;
  localparam logic [5:0] PH_OFFNR   = 6'd15;
  localparam logic [5:0] PH_OFFTB   = 6'd16;
  localparam logic [5:0] PH_CYCLE   = 6'd17;
  localparam logic [5:0] PH_OFFREF  = 6'd18;
  localparam logic [5:0] PH_NREF    = 6'd19;
  localparam logic [5:0] PH_GAPS    = 6'd20;
  localparam logic [5:0] PH_WIDTH   = 6'd21;
  localparam logic [5:0] PH_HEIGHT  = 6'd22;
  localparam logic [5:0] PH_FMO     = 6'd23;
  localparam logic [5:0] PH_MBAFF   = 6'd24;
  localparam logic [5:0] PH_D8      = 6'd25;
  localparam logic [5:0] PH_CROPF   = 6'd26;
  localparam logic [5:0] PH_CROPL   = 6'd27;
  localparam logic [5:0] PH_CROPR   = 6'd28;
  localparam logic [5:0] PH_CROPT   = 6'd29;
  localparam logic [5:0] PH_CROPB   = 6'd30;
  localparam logic [5:0] PH_DONE    = 6'd31;
  localparam logic [5:0] PH_FAIL    = 6'd32;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hdr;
    logic       drop;
  } q_item_t;

  // Length of a fixed-width element; zero marks an exp-Golomb element.
  function automatic logic [3:0] fix_len(input logic [5:0] ph);
    logic [3:0] len;
    begin
      len = 4'd0;
      unique case (ph)
        PH_PROFILE, PH_CONSTR, PH_LEVEL: len = 4'd8;
        PH_SEPCOL, PH_QPBYP, PH_SCALING, PH_DZERO, PH_GAPS,
        PH_FMO, PH_MBAFF, PH_D8, PH_CROPF: len = 4'd1;
        default: len = 4'd0;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

### src/sfp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  profile;
  logic [7:0]  level;
  logic [4:0]  set_id;
  logic [1:0]  chroma_format;
  logic        frames_only;
  logic [15:0] pic_width;
  logic [15:0] pic_height;
  modport source (output valid, output status, output profile, output level,
                  output set_id, output chroma_format, output frames_only,
                  output pic_width, output pic_height, input ready);
  modport sink (input valid, input status, input profile, input level,
                input set_id, input chroma_format, input frames_only,
                input pic_width, input pic_height, output ready);
endinterface

`default_nettype wire

### src/sfp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_fifo
  import sfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  q_item_t      push_item,
  output logic         full,
  input  wire logic    pop,
  output q_item_t      pop_item,
  output logic         not_empty
);

  q_item_t              mem_r [Q_DEPTH];
  logic [QP_W-1:0]      wr_ptr_r;
  logic [QP_W-1:0]      rd_ptr_r;
  logic [QP_W:0]        count_r;

  assign full      = (count_r == (QP_W+1)'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/sfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_front
  import sfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sfp_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      q_push,
  output q_item_t   q_item
);

  logic       hdr_r;
  logic       hdr_nxt;
  logic [1:0] zero_run_r;
  logic [1:0] zero_run_nxt;
  logic       drop;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign drop        = !hdr_r && (zero_run_r == 2'd2) && (in_ch.data_byte == EMU_BYTE);

  always_comb begin
    q_item.data = in_ch.data_byte;
    q_item.last = in_ch.last_byte;
    q_item.hdr  = hdr_r;
    q_item.drop = drop;
  end

  always_comb begin
    hdr_nxt      = hdr_r;
    zero_run_nxt = zero_run_r;
    if (q_push) begin
      hdr_nxt = in_ch.last_byte;
      if (hdr_r || drop || in_ch.last_byte || in_ch.data_byte != 8'h00) begin
        zero_run_nxt = 2'd0;
      end else if (zero_run_r != 2'd2) begin
        zero_run_nxt = zero_run_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= 1'b1;
      zero_run_r <= 2'd0;
    end else begin
      hdr_r      <= hdr_nxt;
      zero_run_r <= zero_run_nxt;
    end
  end

endmodule

`default_nettype wire

### src/sfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfp_back
  import sfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_not_empty,
  input  q_item_t   q_item,
  output logic      q_pop,
  sfp_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BITS = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            last_r, last_nxt;

  logic [5:0]      phase_r, phase_nxt;
  logic [ZW-1:0]   bits_r, bits_nxt;
  logic [ZW-1:0]   zeros_r, zeros_nxt;
  logic [GW-1:0]   val_r, val_nxt;
  logic [7:0]      loop_r, loop_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [7:0]      profile_r, profile_nxt;
  logic [7:0]      level_r, level_nxt;
  logic [4:0]      id_r, id_nxt;
  logic [1:0]      chroma_r, chroma_nxt;
  logic [GW-1:0]   width_r, width_nxt;
  logic [GW-1:0]   height_r, height_nxt;
  logic            fmo_r, fmo_nxt;
  logic            cropf_r, cropf_nxt;
  logic [GW-1:0]   cl_r, cl_nxt;
  logic [GW-1:0]   cr_r, cr_nxt;
  logic [GW-1:0]   ct_r, ct_nxt;
  logic [GW-1:0]   cb_r, cb_nxt;

  logic            out_valid_r;
  logic [2:0]      o_status_r;
  logic [7:0]      o_profile_r;
  logic [7:0]      o_level_r;
  logic [4:0]      o_id_r;
  logic [1:0]      o_chroma_r;
  logic            o_fmo_r;
  logic [15:0]     o_width_r;
  logic [15:0]     o_height_r;

  logic            take;
  logic            hdr_take;
  logic            feed;
  logic            bit_in;
  logic            active;
  logic [3:0]      fl;
  logic [GW-1:0]   val_sh;
  logic            fin;
  logic [GW-1:0]   fin_v;
  logic            start;
  logic [5:0]      nph;
  logic            out_load;

  logic [SZ_W-1:0] ww, hh, cw, ch, w_fin, h_fin;
  logic            size_ok;
  logic [2:0]      res_status;

  assign out_load = (state_r == S_RES) && (!out_valid_r || out_ch.ready);
  assign take = q_not_empty &&
                ((state_r == S_IDLE) ||
                 ((state_r == S_BITS) && (cnt_r == 3'd7) && !last_r &&
                  !q_item.hdr && !q_item.drop));
  assign q_pop    = take;
  assign hdr_take = take && q_item.hdr;
  assign feed     = (state_r == S_BITS);
  assign bit_in   = byte_r[7];

  always_comb begin
    state_nxt = state_r;
    byte_nxt  = byte_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    if (state_r == S_BITS) begin
      byte_nxt = {byte_r[6:0], 1'b0};
      cnt_nxt  = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        state_nxt = last_r ? S_RES : S_IDLE;
      end
    end
    if (take) begin
      if (q_item.hdr || q_item.drop) begin
        state_nxt = q_item.last ? S_RES : S_IDLE;
      end else begin
        state_nxt = S_BITS;
        byte_nxt  = q_item.data;
        cnt_nxt   = 3'd0;
        last_nxt  = q_item.last;
      end
    end
    if (out_load) begin
      state_nxt = S_IDLE;
    end
  end

  // Bit-serial syntax element decoder.
  always_comb begin
    phase_nxt   = phase_r;
    bits_nxt    = bits_r;
    zeros_nxt   = zeros_r;
    val_nxt     = val_r;
    loop_nxt    = loop_r;
    err_nxt     = err_r;
    profile_nxt = profile_r;
    level_nxt   = level_r;
    id_nxt      = id_r;
    chroma_nxt  = chroma_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    fmo_nxt     = fmo_r;
    cropf_nxt   = cropf_r;
    cl_nxt      = cl_r;
    cr_nxt      = cr_r;
    ct_nxt      = ct_r;
    cb_nxt      = cb_r;
    fin         = 1'b0;
    fin_v       = '0;
    start       = 1'b0;
    nph         = phase_r;
    active      = (phase_r >= PH_PROFILE) && (phase_r <= PH_CROPB);
    fl          = fix_len(phase_r);
    val_sh      = {val_r[GW-2:0], bit_in};

    if (feed && active) begin
      if (fl != 4'd0) begin
        val_nxt  = val_sh;
        bits_nxt = bits_r - 1'b1;
        if (bits_r == ZW'(1)) begin
          fin   = 1'b1;
          fin_v = val_sh;
        end
      end else if (bits_r == '0) begin
        if (!bit_in) begin
          if (zeros_r >= ZW'(MAX_LEAD_ZEROS)) begin
            phase_nxt = PH_FAIL;
            err_nxt   = ST_CODE_LONG;
          end else begin
            zeros_nxt = zeros_r + 1'b1;
          end
        end else if (zeros_r == '0) begin
          fin = 1'b1;
        end else begin
          bits_nxt = zeros_r;
          val_nxt  = '0;
        end
      end else begin
        val_nxt  = val_sh;
        bits_nxt = bits_r - 1'b1;
        if (bits_r == ZW'(1)) begin
          fin   = 1'b1;
          fin_v = ((GW'(1) << zeros_r) - GW'(1)) + val_sh;
        end
      end
    end

    if (fin) begin
      start = 1'b1;
      unique case (phase_r)
        PH_PROFILE: begin profile_nxt = fin_v[7:0]; nph = PH_CONSTR; end
        PH_CONSTR:  nph = PH_LEVEL;
        PH_LEVEL:   begin level_nxt = fin_v[7:0]; nph = PH_ID; end
        PH_ID: begin
          if (fin_v > GW'(31)) begin
            start = 1'b0;
          end else begin
            id_nxt = fin_v[4:0];
            nph    = (profile_r == PROFILE_HIGH) ? PH_CHROMA : PH_LOG2FN;
          end
        end
        PH_CHROMA: begin
          if (fin_v > GW'(3)) begin
            start = 1'b0;
          end else begin
            chroma_nxt = fin_v[1:0];
            nph        = (fin_v == GW'(3)) ? PH_SEPCOL : PH_DEPTHL;
          end
        end
        PH_SEPCOL: nph = PH_DEPTHL;
        PH_DEPTHL: begin start = (fin_v <= GW'(6)); nph = PH_DEPTHC; end
        PH_DEPTHC: begin start = (fin_v <= GW'(6)); nph = PH_QPBYP; end
        PH_QPBYP:  nph = PH_SCALING;
        PH_SCALING: begin start = (fin_v == '0); nph = PH_LOG2FN; end
        PH_LOG2FN: begin start = (fin_v <= GW'(12)); nph = PH_POCTYPE; end
        PH_POCTYPE: begin
          start = (fin_v <= GW'(2));
          nph   = (fin_v == '0) ? PH_POCLSB :
                  ((fin_v == GW'(1)) ? PH_DZERO : PH_NREF);
        end
        PH_POCLSB: begin start = (fin_v <= GW'(12)); nph = PH_NREF; end
        PH_DZERO:  nph = PH_OFFNR;
        PH_OFFNR:  nph = PH_OFFTB;
        PH_OFFTB:  nph = PH_CYCLE;
        PH_CYCLE: begin
          start    = (fin_v <= GW'(255));
          loop_nxt = fin_v[7:0];
          nph      = (fin_v == '0) ? PH_NREF : PH_OFFREF;
        end
        PH_OFFREF: begin
          loop_nxt = loop_r - 8'd1;
          nph      = (loop_r == 8'd1) ? PH_NREF : PH_OFFREF;
        end
        PH_NREF:   nph = PH_GAPS;
        PH_GAPS:   nph = PH_WIDTH;
        PH_WIDTH:  begin width_nxt = fin_v; nph = PH_HEIGHT; end
        PH_HEIGHT: begin height_nxt = fin_v; nph = PH_FMO; end
        PH_FMO: begin
          fmo_nxt = fin_v[0];
          nph     = fin_v[0] ? PH_D8 : PH_MBAFF;
        end
        PH_MBAFF:  nph = PH_D8;
        PH_D8:     nph = PH_CROPF;
        PH_CROPF: begin
          cropf_nxt = fin_v[0];
          nph       = fin_v[0] ? PH_CROPL : PH_DONE;
        end
        PH_CROPL:  begin cl_nxt = fin_v; nph = PH_CROPR; end
        PH_CROPR:  begin cr_nxt = fin_v; nph = PH_CROPT; end
        PH_CROPT:  begin ct_nxt = fin_v; nph = PH_CROPB; end
        PH_CROPB:  begin cb_nxt = fin_v; nph = PH_DONE; end
        default:   start = 1'b0;
      endcase
      if (!start) begin
        phase_nxt = PH_FAIL;
        err_nxt   = (phase_r == PH_SCALING) ? ST_SCALING : ST_RANGE;
      end
    end

    if (start) begin
      phase_nxt = nph;
      bits_nxt  = ZW'(fix_len(nph));
      zeros_nxt = '0;
      val_nxt   = '0;
    end

    if (hdr_take) begin
      bits_nxt    = '0;
      zeros_nxt   = '0;
      val_nxt     = '0;
      loop_nxt    = '0;
      profile_nxt = '0;
      level_nxt   = '0;
      id_nxt      = '0;
      chroma_nxt  = 2'd1;
      width_nxt   = '0;
      height_nxt  = '0;
      fmo_nxt     = 1'b0;
      cropf_nxt   = 1'b0;
      cl_nxt      = '0;
      cr_nxt      = '0;
      ct_nxt      = '0;
      cb_nxt      = '0;
      if (q_item.data[4:0] != NAL_TYPE_SPS) begin
        phase_nxt = PH_FAIL;
        err_nxt   = ST_NOT_SPS;
      end else begin
        phase_nxt = PH_PROFILE;
        err_nxt   = ST_OK;
        bits_nxt  = ZW'(fix_len(PH_PROFILE));
      end
    end else if (out_load) begin
      phase_nxt = PH_HEADER;
      err_nxt   = ST_OK;
    end
  end

  // Cropped picture size, its range check and the result status.
  always_comb begin
    ww = SZ_W'(width_r + GW'(1)) << MB_SHIFT;
    hh = (SZ_W'(height_r + GW'(1)) << MB_SHIFT) << (fmo_r ? 1'b0 : 1'b1);
    cw = SZ_W'(cl_r) + SZ_W'(cr_r);
    if (chroma_r == 2'd1 || chroma_r == 2'd2) begin
      cw = cw << 1;
    end
    ch = SZ_W'(ct_r) + SZ_W'(cb_r);
    if (chroma_r == 2'd1) begin
      ch = ch << 1;
    end
    if (!fmo_r) begin
      ch = ch << 1;
    end
    size_ok = (ww <= SZ_W'(65535)) && (hh <= SZ_W'(65535));
    if (cropf_r) begin
      size_ok = size_ok && (cw < ww) && (ch < hh);
      w_fin   = ww - cw;
      h_fin   = hh - ch;
    end else begin
      w_fin = ww;
      h_fin = hh;
    end
    if (err_r != ST_OK) begin
      res_status = err_r;
    end else if (phase_r != PH_DONE) begin
      res_status = ST_TRUNC;
    end else if (!size_ok) begin
      res_status = ST_RANGE;
    end else begin
      res_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_HEADER;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r    <= byte_nxt;
    cnt_r     <= cnt_nxt;
    last_r    <= last_nxt;
    bits_r    <= bits_nxt;
    zeros_r   <= zeros_nxt;
    val_r     <= val_nxt;
    loop_r    <= loop_nxt;
    profile_r <= profile_nxt;
    level_r   <= level_nxt;
    id_r      <= id_nxt;
    chroma_r  <= chroma_nxt;
    width_r   <= width_nxt;
    height_r  <= height_nxt;
    fmo_r     <= fmo_nxt;
    cropf_r   <= cropf_nxt;
    cl_r      <= cl_nxt;
    cr_r      <= cr_nxt;
    ct_r      <= ct_nxt;
    cb_r      <= cb_nxt;
    if (out_load) begin
      o_status_r <= res_status;
      if (res_status == ST_OK) begin
        o_profile_r <= profile_r;
        o_level_r   <= level_r;
        o_id_r      <= id_r;
        o_chroma_r  <= chroma_r;
        o_fmo_r     <= fmo_r;
        o_width_r   <= w_fin[15:0];
        o_height_r  <= h_fin[15:0];
      end else begin
        o_profile_r <= '0;
        o_level_r   <= '0;
        o_id_r      <= '0;
        o_chroma_r  <= '0;
        o_fmo_r     <= 1'b0;
        o_width_r   <= '0;
        o_height_r  <= '0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.profile       = o_profile_r;
  assign out_ch.level         = o_level_r;
  assign out_ch.set_id        = o_id_r;
  assign out_ch.chroma_format = o_chroma_r;
  assign out_ch.frames_only   = o_fmo_r;
  assign out_ch.pic_width     = o_width_r;
  assign out_ch.pic_height    = o_height_r;

endmodule

`default_nettype wire

### src/sps_frame_size_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Parses one H.264 sequence parameter set per NAL unit and reports the
// cropped luma size, profile, level, set id, chroma format and field mode,
// with one result for each unit, ended by the request that carries the last
// byte. The front end checks bytes for emulation prevention and queues them;
// the back end decodes the bit stream one bit per cycle while bytes are
// queued, and takes the header byte and dropped 03 bytes without decoding
// bits. After the last bit of a unit the back end waits in a result state
// until the output register is free, then registers the result, and the next
// unit may be accepted while the result waits to be taken.

module sps_frame_size_parser
  import sfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sfp_in_if.sink     in_ch,
  sfp_out_if.source  out_ch
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_not_empty;
  q_item_t q_in;
  q_item_t q_out;

  sfp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  sfp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .not_empty (q_not_empty)
  );

  sfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_item      (q_out),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench
  import sfp_pkg::*;
();

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  profile;
    logic [7:0]  level;
    logic [4:0]  set_id;
    logic [1:0]  chroma_format;
    logic        frames_only;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
  } sps_result_t;

  logic clk;
  logic rst_n;
  sfp_in_if  in_ch();
  sfp_out_if out_ch();

  sps_frame_size_parser uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  sps_result_t pending_sizes[$];
  int   error_count;
  logic stream_done;
  int   out_wait;

  // Predictor state.
  logic [5:0]  phase;
  logic [1:0]  zrun;
  logic [7:0]  nleft;
  logic [4:0]  lzeros;
  logic [16:0] gval;
  logic [16:0] cycles_left;
  logic [16:0] fields [12];
  logic [2:0]  err;

  function automatic logic [3:0] elem_len(input logic [5:0] ph);
    case (ph)
      PH_PROFILE, PH_CONSTR, PH_LEVEL: return 4'd8;
      PH_SEPCOL, PH_QPBYP, PH_SCALING, PH_DZERO, PH_GAPS,
      PH_FMO, PH_MBAFF, PH_D8, PH_CROPF: return 4'd1;
      default: return 4'd0;
    endcase
  endfunction

  task automatic clear_parser();
    phase = PH_HEADER;
    zrun = 2'd0;
    nleft = 8'd0;
    lzeros = 5'd0;
    gval = 17'd0;
    cycles_left = 17'd0;
    for (int i = 0; i < 12; i++) fields[i] = 17'd0;
    err = ST_OK;
  endtask

  task automatic enter(input logic [5:0] ph);
    phase = ph;
    nleft = (ph < PH_DONE) ? 8'(elem_len(ph)) : 8'd0;
    lzeros = 5'd0;
    gval = 17'd0;
  endtask

  task automatic abort(input logic [2:0] code);
    err = code;
    phase = PH_FAIL;
  endtask

  task automatic complete_elem(input longint unsigned v);
    case (phase)
      PH_PROFILE: begin
        fields[0] = 17'(v);
        enter(PH_CONSTR);
      end
      PH_CONSTR: enter(PH_LEVEL);
      PH_LEVEL: begin
        fields[1] = 17'(v);
        enter(PH_ID);
      end
      PH_ID: begin
        if (v > 31) abort(ST_RANGE);
        else begin
          fields[2] = 17'(v);
          enter(fields[0] == PROFILE_HIGH ? PH_CHROMA : PH_LOG2FN);
        end
      end
      PH_CHROMA: begin
        if (v > 3) abort(ST_RANGE);
        else begin
          fields[3] = 17'(v);
          enter(v == 3 ? PH_SEPCOL : PH_DEPTHL);
        end
      end
      PH_SEPCOL: enter(PH_DEPTHL);
      PH_DEPTHL: if (v > 6) abort(ST_RANGE); else enter(PH_DEPTHC);
      PH_DEPTHC: if (v > 6) abort(ST_RANGE); else enter(PH_QPBYP);
      PH_QPBYP: enter(PH_SCALING);
      PH_SCALING: if (v != 0) abort(ST_SCALING); else enter(PH_LOG2FN);
      PH_LOG2FN: if (v > 12) abort(ST_RANGE); else enter(PH_POCTYPE);
      PH_POCTYPE: begin
        if (v > 2) abort(ST_RANGE);
        else enter(v == 0 ? PH_POCLSB : (v == 1 ? PH_DZERO : PH_NREF));
      end
      PH_POCLSB: if (v > 12) abort(ST_RANGE); else enter(PH_NREF);
      PH_DZERO: enter(PH_OFFNR);
      PH_OFFNR: enter(PH_OFFTB);
      PH_OFFTB: enter(PH_CYCLE);
      PH_CYCLE: begin
        if (v > 255) abort(ST_RANGE);
        else begin
          cycles_left = 17'(v);
          enter(v == 0 ? PH_NREF : PH_OFFREF);
        end
      end
      PH_OFFREF: begin
        cycles_left = cycles_left - 17'd1;
        enter(cycles_left == 0 ? PH_NREF : PH_OFFREF);
      end
      PH_NREF: enter(PH_GAPS);
      PH_GAPS: enter(PH_WIDTH);
      PH_WIDTH: begin
        fields[4] = 17'(v);
        enter(PH_HEIGHT);
      end
      PH_HEIGHT: begin
        fields[5] = 17'(v);
        enter(PH_FMO);
      end
      PH_FMO: begin
        fields[6] = 17'(v);
        enter(v != 0 ? PH_D8 : PH_MBAFF);
      end
      PH_MBAFF: enter(PH_D8);
      PH_D8: enter(PH_CROPF);
      PH_CROPF: begin
        fields[7] = 17'(v);
        enter(v != 0 ? PH_CROPL : PH_DONE);
      end
      PH_CROPL: begin
        fields[8] = 17'(v);
        enter(PH_CROPR);
      end
      PH_CROPR: begin
        fields[9] = 17'(v);
        enter(PH_CROPT);
      end
      PH_CROPT: begin
        fields[10] = 17'(v);
        enter(PH_CROPB);
      end
      PH_CROPB: begin
        fields[11] = 17'(v);
        enter(PH_DONE);
      end
      default: ;
    endcase
  endtask

  task automatic decode_bit(input logic b);
    if (phase < PH_PROFILE || phase > PH_CROPB) return;
    if (elem_len(phase) != 0) begin
      gval = {gval[15:0], b};
      nleft--;
      if (nleft == 0) complete_elem(gval);
    end else if (nleft == 0) begin
      if (!b) begin
        if (lzeros >= MAX_LEAD_ZEROS) abort(ST_CODE_LONG);
        else lzeros++;
      end else if (lzeros == 0) begin
        complete_elem(0);
      end else begin
        nleft = 8'(lzeros);
        gval = 17'd0;
      end
    end else begin
      gval = {gval[15:0], b};
      nleft--;
      if (nleft == 0) complete_elem(((64'd1 << lzeros) - 1) + gval);
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    sps_result_t r;
    longint unsigned ww, hh, cw, ch, fmo;
    int sw, sh;
    if (phase == PH_HEADER) begin
      clear_parser();
      if (b[4:0] != NAL_TYPE_SPS) abort(ST_NOT_SPS);
      else begin
        fields[3] = 17'd1;
        enter(PH_PROFILE);
      end
    end else if (zrun == 2 && b == EMU_BYTE) begin
      zrun = 2'd0;
    end else begin
      zrun = (b == 0) ? ((zrun < 2) ? zrun + 2'd1 : 2'd2) : 2'd0;
      for (int i = 7; i >= 0; i--) decode_bit(b[i]);
    end
    if (!last) return;
    r = '0;
    r.status = err;
    if (r.status == ST_OK && phase != PH_DONE) r.status = ST_TRUNC;
    if (r.status == ST_OK) begin
      fmo = fields[6][0];
      sw = (fields[3][1:0] == 1 || fields[3][1:0] == 2) ? 2 : 1;
      sh = (fields[3][1:0] == 1) ? 2 : 1;
      ww = (longint'(fields[4]) + 1) * 16;
      hh = (longint'(fields[5]) + 1) * 16 * (2 - fmo);
      if (ww > 65535 || hh > 65535) r.status = ST_RANGE;
      else if (fields[7] != 0) begin
        cw = (longint'(fields[8]) + fields[9]) * sw;
        ch = (longint'(fields[10]) + fields[11]) * sh * (2 - fmo);
        if (cw >= ww || ch >= hh) r.status = ST_RANGE;
        else begin
          ww -= cw;
          hh -= ch;
        end
      end
    end
    if (r.status == ST_OK) begin
      r.profile = fields[0][7:0];
      r.level = fields[1][7:0];
      r.set_id = fields[2][4:0];
      r.chroma_format = fields[3][1:0];
      r.frames_only = fields[6][0];
      r.pic_width = ww[15:0];
      r.pic_height = hh[15:0];
    end
    pending_sizes.push_back(r);
    clear_parser();
  endtask

  // Bit writer for building well-formed units.
  logic bitbuf[$];

  task automatic put_bits(input longint unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) bitbuf.push_back(v[i]);
  endtask

  task automatic put_ue(input longint unsigned v);
    longint unsigned c;
    int n;
    c = v + 1;
    n = 0;
    while ((c >> (n + 1)) != 0) n++;
    put_bits(0, n);
    put_bits(c, n + 1);
  endtask

  task automatic put_se(input int v);
    put_ue(v > 0 ? 2 * v - 1 : -2 * v);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    predict_byte(b, last);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sends the header and the packed payload, adding emulation bytes and cutting trunc_bytes at the end.
  task automatic send_unit(input logic [7:0] hdr, input int trunc_bytes);
    logic [7:0] bytes[$];
    logic [7:0] b;
    int zeros;
    while (bitbuf.size() % 8 != 0) bitbuf.push_back(1'b0);
    zeros = 0;
    while (bitbuf.size() > 0) begin
      b = 0;
      for (int i = 0; i < 8; i++) b = {b[6:0], bitbuf.pop_front()};
      if (zeros >= 2 && b <= 3) begin
        bytes.push_back(EMU_BYTE);
        zeros = 0;
      end
      bytes.push_back(b);
      zeros = (b == 0) ? zeros + 1 : 0;
    end
    while (trunc_bytes > 0 && bytes.size() > 0) begin
      void'(bytes.pop_back());
      trunc_bytes--;
    end
    send_byte(hdr, bytes.size() == 0);
    for (int i = 0; i < bytes.size(); i++) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic build_sps(input logic [7:0] prof, input int bad);
    int cf, poc, ncyc, fmo;
    put_bits(prof, 8);
    put_bits($urandom, 8);
    put_bits($urandom, 8);
    put_ue(bad == 1 ? 32 : $urandom_range(0, 31));
    if (prof == PROFILE_HIGH) begin
      cf = $urandom_range(0, 3);
      put_ue(bad == 2 ? 4 : cf);
      if (cf == 3) put_bits($urandom, 1);
      put_ue(bad == 3 ? 7 : $urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_bits($urandom, 1);
      put_bits(bad == 4 ? 1 : 0, 1);
    end else begin
      cf = 1;
    end
    put_ue(bad == 5 ? 13 : $urandom_range(0, 12));
    poc = (bad == 6) ? 3 : $urandom_range(0, 2);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(0, 12));
    if (poc == 1) begin
      put_bits($urandom, 1);
      put_se($signed($urandom_range(0, 2000)) - 1000);
      put_se($signed($urandom_range(0, 200)) - 100);
      ncyc = (bad == 7) ? 256 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 4));
      put_ue(ncyc);
      if (ncyc <= 255) for (int i = 0; i < ncyc; i++) put_se($signed($urandom_range(0, 64)) - 32);
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom, 1);
    put_ue($urandom_range(0, 7) == 0 ? $urandom_range(0, 5000) : $urandom_range(0, 120));
    put_ue($urandom_range(0, 7) == 0 ? $urandom_range(0, 5000) : $urandom_range(0, 80));
    fmo = $urandom_range(0, 1);
    put_bits(fmo, 1);
    if (!fmo) put_bits($urandom, 1);
    put_bits($urandom, 1);
    if ($urandom_range(0, 1)) begin
      put_bits(1, 1);
      for (int i = 0; i < 4; i++)
        put_ue($urandom_range(0, 5) == 0 ? $urandom_range(0, 3000) : $urandom_range(0, 8));
    end else begin
      put_bits(0, 1);
    end
    if ($urandom_range(0, 1)) put_bits($urandom, $urandom_range(1, 24));
  endtask

  task automatic test_directed();
    // Minimal baseline unit: all codes at zero, no crop.
    put_bits(66, 8); put_bits(0, 8); put_bits(30, 8);
    put_ue(0); put_ue(0); put_ue(0); put_ue(0); put_ue(0);
    put_bits(0, 1); put_ue(0); put_ue(0); put_bits(1, 1); put_bits(0, 1); put_bits(0, 1);
    send_unit(8'h67, 0);
    send_byte(8'h65, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h27, 1'b1);
    put_bits(8'hff, 8); put_bits(8'hff, 8); put_bits(8'hff, 8); put_ue(31);
    send_unit(8'hf7, 0);
    put_bits(77, 8); put_bits(0, 16); put_bits(0, 17);
    send_unit(8'h67, 0);
    // Raw zero runs with an emulation byte and an extra 03 pass-through.
    send_byte(8'h67, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b1);
  endtask

  task automatic test_high_profile();
    for (int i = 0; i < 20; i++) begin
      build_sps(PROFILE_HIGH, 0);
      send_unit(8'h67, 0);
    end
  endtask

  task automatic test_errors();
    for (int k = 1; k <= 7; k++) begin
      build_sps(PROFILE_HIGH, k);
      send_unit(8'h67, 0);
    end
  endtask

  task automatic test_random();
    int n;
    logic [7:0] prof;
    n = 0;
    while (n < 640) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int i = $urandom_range(0, 12); i >= 0; i--) begin
            send_byte(i == 0 ? 8'($urandom) : 8'($urandom_range(0, 3) * 85), i == 0);
            n++;
          end
        end
        1: begin
          build_sps($urandom_range(0, 1) ? PROFILE_HIGH : 8'd66, 0);
          n += bitbuf.size() / 8 + 1;
          send_unit({3'($urandom_range(0, 7)), 5'd7}, $urandom_range(1, 6));
        end
        default: begin
          prof = $urandom_range(0, 2) == 0 ? 8'($urandom) : PROFILE_HIGH;
          build_sps(prof, $urandom_range(0, 9) == 0 ? $urandom_range(1, 7) : 0);
          n += bitbuf.size() / 8 + 1;
          send_unit({3'($urandom_range(0, 7)), 5'd7}, 0);
        end
      endcase
    end
  endtask

  // The result side draws a wait for every result it takes.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= $urandom_range(0, 6);
    end else if (out_ch.valid && out_ch.ready) begin
      w = $urandom_range(0, 6);
      out_wait <= w;
      out_ch.ready <= (w == 0);
    end else if (out_wait != 0) begin
      out_wait <= out_wait - 1;
      out_ch.ready <= (out_wait == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sps_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_sizes.size() == 0) begin
        $error("Result with no request pending");
        error_count++;
      end else begin
        e = pending_sizes.pop_front();
        if (out_ch.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, out_ch.status); error_count++;
        end
        if (out_ch.profile !== e.profile) begin
          $error("profile expected %0d got %0d", e.profile, out_ch.profile); error_count++;
        end
        if (out_ch.level !== e.level) begin
          $error("level expected %0d got %0d", e.level, out_ch.level); error_count++;
        end
        if (out_ch.set_id !== e.set_id) begin
          $error("set_id expected %0d got %0d", e.set_id, out_ch.set_id); error_count++;
        end
        if (out_ch.chroma_format !== e.chroma_format) begin
          $error("chroma_format expected %0d got %0d", e.chroma_format,
                 out_ch.chroma_format);
          error_count++;
        end
        if (out_ch.frames_only !== e.frames_only) begin
          $error("frames_only expected %0d got %0d", e.frames_only, out_ch.frames_only);
          error_count++;
        end
        if (out_ch.pic_width !== e.pic_width) begin
          $error("pic_width expected %0d got %0d", e.pic_width, out_ch.pic_width);
          error_count++;
        end
        if (out_ch.pic_height !== e.pic_height) begin
          $error("pic_height expected %0d got %0d", e.pic_height, out_ch.pic_height);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int wait_cycles;
    error_count = 0;
    stream_done = 1'b0;
    clear_parser();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_high_profile();
    test_errors();
    test_random();
    in_ch.valid <= 1'b0;
    stream_done = 1'b1;
    wait_cycles = 0;
    while (pending_sizes.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (error_count == 0 && pending_sizes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/sfp_pkg.sv
src/sfp_if.sv
src/sfp_fifo.sv
src/sfp_front.sv
src/sfp_back.sv
src/sps_frame_size_parser.sv
test/testbench.sv
